/* rtl/calibrated_profile_depth_convert_macros.svh */
// Assertion macros shared by the calibrated profile depth converter RTL.
// No dependencies; included by the top level, which carries the assertions.
`ifndef CALIBRATED_PROFILE_DEPTH_CONVERT_MACROS_SVH
`define CALIBRATED_PROFILE_DEPTH_CONVERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define CPDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cpdc assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define CPDC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cpdc assertion failed");
`else
`define CPDC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CPDC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/cpdc_pkg.sv */
// Package for the calibrated profile depth converter: opcodes, constants, FSM type.
// No dependencies; imported by the top level and the testbench.
package cpdc_pkg;

	localparam logic OP_CONVERT = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	localparam int unsigned DEPTH_MAX     = 199;
	localparam int unsigned POINT_SPACING = 10;

	localparam int unsigned CODE_W  = 12;
	localparam int unsigned NUM_W   = 16;
	localparam int unsigned QUO_W   = 4;
	localparam int unsigned DEPTH_W = 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} cpdc_state_t;

endpackage

/* rtl/cpdc_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; used for the calibration table.
module cpdc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/calibrated_profile_depth_convert.sv */
// Top level of the calibrated profile depth converter (piecewise linear lookup).
// Depends on cpdc_pkg, cpdc_ram and calibrated_profile_depth_convert_macros.svh.
//
// Usage: items arrive on the s_axis channel. tuser carries the opcode: a load beat
// writes one 12-bit calibration code into a sensor's row and returns nothing; a
// convert beat walks that sensor's row of descending codes to the first point not
// above the sample and returns one beat on m_axis with the interpolated depth in
// millimetres (tdata) and an off-table flag (tuser).
// Flow: a load is written while the block stays idle. A convert issues the first table
// read while idle, visits one calibration point per cycle (the walk is bounded by the
// single read port of the table RAM, up to POINT_COUNT points), runs a four-bit
// restoring division when interpolation is needed, and then hands over the result
// once the output slot is free.
// The block takes one item at a time; s_axis_tready is high only while it is idle.
// The result sits in an output register, so a stalled receiver does not hold up
// loads or the next convert; only a second finished result waits for the slot.
// Reset clears control state and the output register; the table itself is not
// cleared and each entry must be loaded before a convert reads it.
module calibrated_profile_depth_convert #(
	parameter int SENSOR_COUNT = 32,
	parameter int POINT_COUNT  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sensor_index[4:0], point_index[9:5], sample[21:10], entry_value[33:22], zero pad
	input  logic [39:0] s_axis_tdata,
	// opcode[0]
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// depth_mm[7:0]
	output logic [7:0]  m_axis_tdata,
	// off_table[0]
	output logic [0:0]  m_axis_tuser
);

	import cpdc_pkg::*;
	`include "calibrated_profile_depth_convert_macros.svh"

	// Rows are padded to a power of two so that the address is {sensor, point}.
	localparam int PW    = $clog2(POINT_COUNT);
	localparam int SW    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int DEPTH = SENSOR_COUNT * (1 << PW);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW    = PW + 4;

	// Input beat fields.
	logic [4:0]        in_sensor;
	logic [4:0]        in_point;
	logic [CODE_W-1:0] in_sample;
	logic [CODE_W-1:0] in_value;
	logic              in_op;
	logic              in_acc;
	logic              sensor_ok;
	logic              point_ok;
	logic [SW+5:0]     sensor_wide;
	logic [PW+5:0]     point_wide;
	logic [SW-1:0]     in_row;
	logic [PW-1:0]     in_pt;

	assign in_sensor   = s_axis_tdata[4:0];
	assign in_point    = s_axis_tdata[9:5];
	assign in_sample   = s_axis_tdata[21:10];
	assign in_value    = s_axis_tdata[33:22];
	assign in_op       = s_axis_tuser[0];
	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign sensor_ok   = 32'(in_sensor) < 32'(SENSOR_COUNT);
	assign point_ok    = 32'(in_point) < 32'(POINT_COUNT);
	assign sensor_wide = (SW + 6)'(in_sensor);
	assign point_wide  = (PW + 6)'(in_point);
	assign in_row      = sensor_wide[SW-1:0];
	assign in_pt       = point_wide[PW-1:0];

	// Control and working registers.
	cpdc_state_t         state_q;
	logic [SW-1:0]       row_q;
	logic [CODE_W-1:0]   sample_q;
	logic [PW-1:0]       ptr_q;
	logic [CODE_W-1:0]   prev_q;
	logic [NUM_W-1:0]    rem_q;
	logic [CODE_W-1:0]   den_q;
	logic [1:0]          bit_q;
	logic [QUO_W-1:0]    quo_q;
	logic [DEPTH_W-1:0]  res_depth_q;
	logic                res_off_q;
	logic                m_valid_q;
	logic [DEPTH_W-1:0]  m_depth_q;
	logic                m_off_q;

	// Table RAM.
	logic                ram_we;
	logic [SW+PW-1:0]    waddr_full;
	logic [SW+PW-1:0]    raddr_full;
	logic [PW-1:0]       ptr_next;
	logic [CODE_W-1:0]   rdata;

	assign ptr_next   = ptr_q + PW'(1);
	assign ram_we     = in_acc && (in_op == OP_LOAD) && sensor_ok && point_ok;
	assign waddr_full = {in_row, in_pt};
	// While idle the first point of the incoming sensor is fetched speculatively;
	// during the walk the point after the one being compared is fetched.
	assign raddr_full = (state_q == ST_IDLE) ? {in_row, PW'(0)} : {row_q, ptr_next};

	cpdc_ram #(
		.WIDTH(CODE_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_full[AW-1:0]),
		.wdata(in_value),
		.raddr(raddr_full[AW-1:0]),
		.rdata(rdata)
	);

	// Walk and division datapath.
	logic                hit;
	logic                ptr_last;
	logic                ptr_low;
	logic [CODE_W-1:0]   num_diff;
	logic [NUM_W-1:0]    num_init;
	logic [NUM_W-1:0]    trial;
	logic                q_bit;
	logic [QUO_W-1:0]    quo_final;
	logic [DW-1:0]       depth_raw;
	logic [DEPTH_W-1:0]  depth_clamped;
	logic                out_free;

	assign hit      = sample_q >= rdata;
	assign ptr_last = ptr_q == PW'(POINT_COUNT - 1);
	assign ptr_low  = ptr_q <= PW'(1);
	assign num_diff = prev_q - sample_q;
	assign num_init = NUM_W'(num_diff) * NUM_W'(POINT_SPACING);
	assign trial    = NUM_W'(den_q) << bit_q;
	assign q_bit    = rem_q >= trial;

	always_comb begin
		quo_final        = quo_q;
		quo_final[bit_q] = q_bit;
	end

	assign depth_raw     = DW'(ptr_q) * DW'(POINT_SPACING) + DW'(quo_final);
	assign depth_clamped = (32'(depth_raw) > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX)
		: DEPTH_W'(depth_raw);

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_op == OP_CONVERT)) begin
						state_q <= sensor_ok ? ST_WALK : ST_FIN;
					end
				end
				ST_WALK: begin
					if (hit) begin
						state_q <= ptr_low ? ST_FIN : ST_DIV;
					end else if (ptr_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (bit_q == 2'd0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				row_q       <= in_row;
				sample_q    <= in_sample;
				ptr_q       <= '0;
				res_depth_q <= '0;
				res_off_q   <= 1'b0;
			end
			ST_WALK: begin
				if (hit) begin
					rem_q <= num_init;
					den_q <= prev_q - rdata;
					bit_q <= 2'd3;
					quo_q <= '0;
				end else if (ptr_last) begin
					res_depth_q <= DEPTH_W'(DEPTH_MAX);
					res_off_q   <= 1'b1;
				end else begin
					prev_q <= rdata;
					ptr_q  <= ptr_next;
				end
			end
			ST_DIV: begin
				quo_q <= quo_final;
				if (q_bit) begin
					rem_q <= rem_q - trial;
				end
				bit_q <= bit_q - 2'd1;
				if (bit_q == 2'd0) begin
					res_depth_q <= depth_clamped;
					res_off_q   <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded from the result when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_depth_q <= '0;
			m_off_q   <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			m_valid_q <= 1'b1;
			m_depth_q <= res_depth_q;
			m_off_q   <= res_off_q;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_depth_q;
	assign m_axis_tuser[0] = m_off_q;

	// Interpolation only starts between two points that bracket the sample.
	`CPDC_ASSERT_IMP(a_bracket, clk, arst_n,
		(state_q == ST_WALK) && hit && !ptr_low, prev_q > sample_q)
	// The divisor of the interpolation is never zero.
	`CPDC_ASSERT_IMP(a_den_nz, clk, arst_n, state_q == ST_DIV, den_q != '0)
	// Restoring division invariant: the remainder stays below the divisor scaled
	// to the next quotient bit, so the quotient never reaches sixteen.
	`CPDC_ASSERT_IMP(a_rem_bound, clk, arst_n, state_q == ST_DIV,
		{1'b0, rem_q} < ((NUM_W + 1)'(den_q) << ({1'b0, bit_q} + 3'd1)))
	// Results never exceed the clamp, and off-table results carry the clamp value.
	`CPDC_ASSERT_IMP(a_out_range, clk, arst_n, m_valid_q,
		(32'(m_depth_q) <= DEPTH_MAX) && (!m_off_q || (32'(m_depth_q) == DEPTH_MAX)))
	// A load beat returns the block to idle at once.
	`CPDC_ASSERT_NXT(a_load_idle, clk, arst_n, in_acc && (in_op == OP_LOAD),
		state_q == ST_IDLE)

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for calibrated_profile_depth_convert: loads calibration rows,
// converts samples and checks every result beat against a predictor kept in this file.
// Depends on cpdc_pkg and the converter RTL; needs no files or arguments at run time.
`timescale 1ns / 1ps

module tb_top;
	import cpdc_pkg::*;

	localparam int SENSORS     = 32;
	localparam int ROW_POINTS  = 32;
	// The drain wait covers two worst-case converts.
	localparam int DRAIN_CYCLES = 2 * (ROW_POINTS + 6);
	// Longest legal silence is the deliberate receiver hold-off (HOLD_CYCLES) plus one
	// convert; random gaps are short. The limit is several times that.
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [7:0] depth_mm;
		logic       off_table;
	} depth_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	// Shadow of the calibration table and which entries have been loaded.
	logic [11:0] cal_codes [SENSORS][ROW_POINTS];
	bit          loaded [SENSORS][ROW_POINTS];

	depth_result_t depth_expect_q[$];

	int src_gap_pct = 0;
	int sink_gap_pct = 0;
	int ready_hold_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	calibrated_profile_depth_convert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Walk the row to the first code not above the sample, then interpolate between
	// the two neighboring points (10 mm apart) and clamp.
	function automatic depth_result_t depth_from_row(input logic [4:0] sensor,
			input logic [11:0] code);
		depth_result_t res;
		int unsigned p;
		int unsigned upper;
		int unsigned lower;
		int unsigned mm;
		res = '0;
		p = 0;
		while (p < ROW_POINTS && code < cal_codes[sensor][5'(p)])
			p++;
		if (p >= ROW_POINTS) begin
			res.depth_mm = 8'(DEPTH_MAX);
			res.off_table = 1'b1;
		end else if (p >= 2) begin
			upper = 32'(cal_codes[sensor][5'(p - 1)]);
			lower = 32'(cal_codes[sensor][5'(p)]);
			mm = POINT_SPACING * p;
			if (upper > lower)
				mm += (POINT_SPACING * (upper - 32'(code))) / (upper - lower);
			if (mm > DEPTH_MAX)
				mm = DEPTH_MAX;
			res.depth_mm = mm[7:0];
		end
		return res;
	endfunction

	// True when a convert of this sample only touches entries that were loaded.
	function automatic bit walk_stays_loaded(input logic [4:0] sensor,
			input logic [11:0] code);
		for (int p = 0; p < ROW_POINTS; p++) begin
			if (!loaded[sensor][5'(p)])
				return 1'b0;
			if (code >= cal_codes[sensor][5'(p)])
				return 1'b1;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Drives one input beat at the falling edge and waits for it to be taken. The
	// valid is only dropped when a gap is inserted, never between back-to-back beats.
	task automatic send_beat(input logic op, input logic [4:0] sensor,
			input logic [4:0] point, input logic [11:0] code, input logic [11:0] entry);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, entry, code, point, sensor};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (op == OP_LOAD) begin
			cal_codes[sensor][point] = entry;
			loaded[sensor][point] = 1'b1;
		end else begin
			depth_expect_q.push_back(depth_from_row(sensor, code));
		end
	endtask

	// The fields a beat does not use still carry random bits.
	task automatic send_load(input logic [4:0] sensor, input logic [4:0] point,
			input logic [11:0] entry);
		send_beat(OP_LOAD, sensor, point, 12'($urandom_range(0, 4095)), entry);
	endtask

	task automatic send_convert(input logic [4:0] sensor, input logic [11:0] code);
		send_beat(OP_CONVERT, sensor, 5'($urandom_range(0, 31)), code,
			12'($urandom_range(0, 4095)));
	endtask

	// Loads points 0..count-1 with descending codes, now and then a flat step. The
	// step size leaves room so the last point of a full row stays above zero.
	task automatic load_descending_row(input logic [4:0] sensor, input int count);
		int prev;
		int rem;
		int avail;
		int lim;
		int step;
		prev = ($urandom_range(0, 3) == 0) ? 4095 : int'($urandom_range(2500, 4095));
		for (int p = 0; p < count; p++) begin
			if (p > 0) begin
				rem = ROW_POINTS - 1 - p;
				avail = (prev > rem) ? prev - rem - 1 : 0;
				lim = (avail * 2) / (rem + 1);
				if (lim > avail)
					lim = avail;
				step = (lim == 0 || $urandom_range(0, 19) == 0) ? 0 :
					int'($urandom_range(1, lim));
				prev = prev - step;
			end
			send_load(sensor, 5'(p), 12'(prev));
		end
	endtask

	// Loads point 0 if it is missing; else picks a sample that is uniform, an extreme,
	// or near a stored code, and uses full scale if the walk would reach an unloaded entry.
	task automatic convert_random(input logic [4:0] sensor);
		logic [11:0] code;
		int p;
		int nearby;
		if (!loaded[sensor][0]) begin
			send_load(sensor, 5'd0, 12'($urandom_range(0, 4095)));
			return;
		end
		case ($urandom_range(0, 9))
			0: code = 12'h000;
			1: code = 12'hFFF;
			2, 3, 4, 5: code = 12'($urandom_range(0, 4095));
			default: begin
				p = int'($urandom_range(0, ROW_POINTS - 1));
				if (!loaded[sensor][5'(p)])
					p = 0;
				nearby = int'(cal_codes[sensor][5'(p)]) + int'($urandom_range(0, 4)) - 2;
				if (nearby < 0)
					nearby = 0;
				if (nearby > 4095)
					nearby = 4095;
				code = 12'(nearby);
			end
		endcase
		if (!walk_stays_loaded(sensor, code))
			code = 12'hFFF;
		send_convert(sensor, code);
	endtask

	// Short rows: first and second point give zero, exact codes, truncating divide,
	// and the extremes of the sensor, point and code fields.
	task automatic test_directed_points();
		send_load(5'd5, 5'd0, 12'd4095);
		send_load(5'd5, 5'd1, 12'd3000);
		send_load(5'd5, 5'd2, 12'd2000);
		send_load(5'd5, 5'd3, 12'd1000);
		send_load(5'd31, 5'd31, 12'd0);
		send_load(5'd0, 5'd0, 12'd4095);
		send_convert(5'd5, 12'd4095);
		send_convert(5'd5, 12'd3500);
		send_convert(5'd5, 12'd3000);
		send_convert(5'd5, 12'd2999);
		send_convert(5'd5, 12'd2500);
		send_convert(5'd5, 12'd2000);
		send_convert(5'd5, 12'd1001);
		send_convert(5'd5, 12'd1000);
		send_convert(5'd0, 12'd4095);
	endtask

	// A full row with even spacing: samples below every point, on the last point,
	// and deep enough that the interpolated value must be clamped.
	task automatic test_full_row_limits();
		for (int p = 0; p < ROW_POINTS; p++)
			send_load(5'd31, 5'(p), 12'(4000 - 120 * p));
		send_convert(5'd31, 12'd0);
		send_convert(5'd31, 12'd279);
		send_convert(5'd31, 12'd280);
		send_convert(5'd31, 12'd1720);
		send_convert(5'd31, 12'd1780);
		send_convert(5'd31, 12'd1841);
		send_convert(5'd31, 12'd4000);
		send_convert(5'd31, 12'd3880);
		send_convert(5'd31, 12'd3879);
	endtask

	// The receiver holds off long enough for the output register to fill and a second
	// result to wait inside the block, so the input side must stall.
	task automatic test_output_backpressure();
		ready_hold_left = HOLD_CYCLES;
		repeat (6)
			convert_random(5'd31);
	endtask

	// Mostly whole or partial row loads followed by bursts of converts on that row;
	// the rest are stray loads and converts on arbitrary sensors.
	task automatic test_random_traffic(input int item_budget);
		int sent;
		int kind;
		int npts;
		int nconv;
		logic [4:0] sensor;
		sent = 0;
		while (sent < item_budget) begin
			kind = $urandom_range(0, 99);
			sensor = 5'($urandom_range(0, SENSORS - 1));
			if (kind < 70) begin
				npts = (kind < 45) ? ROW_POINTS : int'($urandom_range(1, ROW_POINTS - 1));
				nconv = $urandom_range(8, 24);
				load_descending_row(sensor, npts);
				repeat (nconv)
					convert_random(sensor);
				sent += npts + nconv;
			end else if (kind < 85) begin
				send_load(sensor, 5'($urandom_range(0, ROW_POINTS - 1)),
					12'($urandom_range(0, 4095)));
				sent++;
			end else begin
				convert_random(sensor);
				sent++;
			end
		end
	endtask

	task automatic wait_for_drain();
		while (depth_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Receiver: random ready, or held low while a hold-off is counting down.
	always @(negedge clk) begin
		if (ready_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold_left = ready_hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
		end
	end

	always @(posedge clk) begin : check_results
		depth_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (depth_expect_q.size() == 0) begin
				report_mismatch("unexpected result beat, depth_mm", int'(m_axis_tdata), -1);
			end else begin
				want = depth_expect_q.pop_front();
				if (m_axis_tdata !== want.depth_mm)
					report_mismatch("depth_mm", int'(m_axis_tdata), int'(want.depth_mm));
				if (m_axis_tuser[0] !== want.off_table)
					report_mismatch("off_table", int'(m_axis_tuser[0]),
						int'(want.off_table));
			end
		end
	end

	// Watchdog on cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;

		src_gap_pct = 18;
		sink_gap_pct = 52;
		test_directed_points();
		test_full_row_limits();
		test_random_traffic(230);

		src_gap_pct = 52;
		sink_gap_pct = 18;
		test_random_traffic(250);

		src_gap_pct = 0;
		sink_gap_pct = 0;
		test_output_backpressure();
		test_random_traffic(230);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_for_drain();

		if (mismatch_count == 0 && depth_expect_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/cpdc_pkg.sv
rtl/cpdc_ram.sv
rtl/calibrated_profile_depth_convert.sv
sim/tb_top.sv
